// ===== rtl/sector_cache_directory_defines.svh =====
// Assertion macros shared by the directory RTL.
`ifndef SECTOR_CACHE_DIRECTORY_DEFINES_SVH
`define SECTOR_CACHE_DIRECTORY_DEFINES_SVH

// Same-cycle implication.
`define SCD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scd: same-cycle check failed");

// Next-cycle implication.
`define SCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scd: next-cycle check failed");

`endif

// ===== rtl/scd_pkg.sv =====
`timescale 1ns / 1ps

package scd_pkg;

   localparam int DEF_SETS  = 256;
   localparam int DEF_WAYS  = 4;
   localparam int TAG_W     = 24;
   localparam int AGE_W     = 32;
   localparam int SECTOR_W  = 32;
   localparam int CMD_W     = 2;
   localparam int SLOT_W    = 10;
   localparam int WAY_IDX_W = 4;

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic step;
      logic first;
   } way_ctl_type;

   typedef struct packed {
      logic                 found;
      logic [WAY_IDX_W-1:0] found_way;
      logic [WAY_IDX_W-1:0] best_way;
   } way_status_type;

endpackage

// ===== rtl/scd_ram.sv =====
`timescale 1ns / 1ps

module scd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/scd_way_unit.sv =====
`timescale 1ns / 1ps

`include "sector_cache_directory_defines.svh"

module scd_way_unit
   import scd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  way_ctl_type          ctl,
   input  entry_type            entry,
   input  logic [TAG_W-1:0]     key_tag,
   input  logic [WAY_IDX_W-1:0] way,
   output way_status_type       status
);

   logic                 match;
   logic                 older;
   logic                 found_ff, found_in;
   logic [WAY_IDX_W-1:0] found_way_ff, found_way_in;
   logic [WAY_IDX_W-1:0] best_way_ff, best_way_in;
   logic [AGE_W-1:0]     best_age_ff, best_age_in;

   // one tag compare and one age compare, reused for every way
   assign match = entry.valid && (entry.tag == key_tag);
   assign older = entry.age < best_age_ff;

   always_comb begin
      found_in     = found_ff;
      found_way_in = found_way_ff;
      best_way_in  = best_way_ff;
      best_age_in  = best_age_ff;
      if (ctl.step) begin
         if (ctl.first) begin
            found_in     = match;
            found_way_in = way;
            best_way_in  = way;
            best_age_in  = entry.age;
         end else begin
            if (!found_ff && match) begin
               found_in     = 1'b1;
               found_way_in = way;
            end
            if (older) begin
               best_way_in = way;
               best_age_in = entry.age;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      found_way_ff <= found_way_in;
      best_way_ff  <= best_way_in;
      best_age_ff  <= best_age_in;
   end

   assign status.found     = found_ff;
   assign status.found_way = found_way_ff;
   assign status.best_way  = best_way_ff;

   `SCD_ASSERT_NEXT(a_match_found, clock, reset, ctl.step && match, found_ff)
   `SCD_ASSERT_NEXT(a_first_match_kept, clock, reset,
      ctl.step && !ctl.first && found_ff, found_ff && $stable(found_way_ff))
   `SCD_ASSERT_NEXT(a_min_age_shrinks, clock, reset,
      ctl.step && !ctl.first, best_age_ff <= $past(best_age_ff))

endmodule

// ===== rtl/sector_cache_directory.sv =====
// Tag and age directory of a set associative sector cache (SETS sets of WAYS
// ways, SETS a power of two). A sector maps to set sector[log2(SETS)-1:0]
// with the next 24 bits as tag; slot = set * WAYS + way, low 10 bits.
// Lookup and enabled fill: the accept cycle reads the whole set row from the
// directory RAM, one shared tag/age compare unit then examines one way per
// cycle, the row is written back (for a fill or a hit), and the item is handed
// to the result register once that register is free. A fill while the cache is
// disabled and an unused command code go straight from accept to that hand-off.
// Invalidate-all sweeps the directory one set per cycle. After reset the same
// sweep runs with req_ready low. A result may wait in its output register
// while the next item is already accepted. The cache_enable register is
// written through csr_write_enable at any time and resets to 1.
`timescale 1ns / 1ps

`include "sector_cache_directory_defines.svh"

module sector_cache_directory
   import scd_pkg::*;
#(
   parameter int SETS = DEF_SETS,
   parameter int WAYS = DEF_WAYS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic                req_starts_request,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hit,
   output logic                rsp_stored,
   output logic [SLOT_W-1:0]   rsp_slot,
   input  logic                csr_write_enable,
   input  logic                csr_write_data
);

   localparam int SET_W = $clog2(SETS);
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W = WAYS * ENTRY_W;
   localparam int SUM_W = SET_W + WAY_IDX_W + 1;
   localparam logic [SET_W-1:0]     LAST_SET = SET_W'(SETS - 1);
   localparam logic [WAY_IDX_W-1:0] LAST_WAY = WAY_IDX_W'(WAYS - 1);

   state_type            state_ff, state_in;
   logic [WAY_IDX_W-1:0] way_ff, way_in;
   logic [SET_W-1:0]     clr_ff, clr_in;
   logic                 enable_ff, enable_in;
   logic [AGE_W-1:0]     timestamp_ff, timestamp_in;
   logic [CMD_W-1:0]     cmd_ff;
   logic [SET_W-1:0]     set_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic                 res_hit_ff, res_hit_in;
   logic                 res_stored_ff, res_stored_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff;
   logic                 rsp_stored_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;

   logic                 req_fire;
   logic                 rsp_free;
   logic                 mem_wr_en;
   logic [SET_W-1:0]     mem_wr_addr;
   logic [ROW_W-1:0]     mem_wr_data;
   logic                 mem_rd_en;
   logic [SET_W-1:0]     mem_rd_addr;
   logic [ROW_W-1:0]     mem_rd_data;
   entry_type [WAYS-1:0] rd_row;
   entry_type [WAYS-1:0] wr_row;
   way_ctl_type          way_ctl;
   way_status_type       way_status;
   logic [WAY_IDX_W-1:0] sel_way;
   logic [SUM_W-1:0]     slot_sum;
   logic                 row_write;

   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rd_row   = mem_rd_data;

   scd_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   scd_way_unit u_way_unit (
      .clock   (clock),
      .reset   (reset),
      .ctl     (way_ctl),
      .entry   (rd_row[way_ff[WAY_W-1:0]]),
      .key_tag (tag_ff),
      .way     (way_ff),
      .status  (way_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (clr_ff == LAST_SET) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_cmd)
                  CMD_LOOKUP: state_in = ST_SCAN;
                  CMD_FILL:   state_in = enable_ff ? ST_SCAN : ST_DONE;
                  CMD_INVAL:  state_in = ST_CLEAR;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (way_ff == LAST_WAY) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            if (clr_ff == LAST_SET) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = set_ff;
      mem_wr_data   = wr_row;
      way_ctl.step  = 1'b0;
      way_ctl.first = (way_ff == '0);
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            mem_rd_en = req_valid;
         end
         ST_SCAN: begin
            way_ctl.step = 1'b1;
         end
         ST_WRITE: begin
            mem_wr_en = row_write;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign mem_rd_addr = req_sector[SET_W-1:0];

   // row write-back and result
   assign row_write = (cmd_ff == CMD_FILL) || way_status.found;
   assign sel_way   = ((cmd_ff == CMD_FILL) && !way_status.found) ?
                      way_status.best_way : way_status.found_way;
   assign slot_sum  = SUM_W'(set_ff) * SUM_W'(WAYS) + SUM_W'(sel_way);

   always_comb begin
      wr_row = rd_row;
      wr_row[sel_way[WAY_W-1:0]].age = timestamp_ff;
      if (cmd_ff == CMD_FILL) begin
         wr_row[sel_way[WAY_W-1:0]].valid = 1'b1;
         wr_row[sel_way[WAY_W-1:0]].tag   = tag_ff;
      end
   end

   always_comb begin
      way_in        = way_ff;
      clr_in        = clr_ff;
      enable_in     = csr_write_enable ? csr_write_data : enable_ff;
      timestamp_in  = timestamp_ff;
      res_hit_in    = res_hit_ff;
      res_stored_in = res_stored_ff;
      res_slot_in   = res_slot_ff;
      if (req_fire) begin
         way_in        = '0;
         clr_in        = '0;
         res_hit_in    = 1'b0;
         res_stored_in = 1'b0;
         res_slot_in   = '0;
         if ((req_cmd == CMD_LOOKUP) && req_starts_request) begin
            timestamp_in = timestamp_ff + AGE_W'(1);
         end
      end
      if (state_ff == ST_SCAN) begin
         way_in = way_ff + WAY_IDX_W'(1);
      end
      if ((state_ff == ST_INIT) || (state_ff == ST_CLEAR)) begin
         clr_in = clr_ff + SET_W'(1);
      end
      if (state_ff == ST_WRITE) begin
         res_hit_in    = way_status.found;
         res_stored_in = (cmd_ff == CMD_FILL);
         res_slot_in   = row_write ? SLOT_W'(slot_sum) : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         way_ff       <= '0;
         clr_ff       <= '0;
         enable_ff    <= 1'b1;
         timestamp_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         way_ff       <= way_in;
         clr_ff       <= clr_in;
         enable_ff    <= enable_in;
         timestamp_ff <= timestamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_cmd;
         set_ff <= req_sector[SET_W-1:0];
         tag_ff <= TAG_W'(req_sector >> SET_W);
      end
      res_hit_ff    <= res_hit_in;
      res_stored_ff <= res_stored_in;
      res_slot_ff   <= res_slot_in;
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_hit_ff    <= res_hit_ff;
         rsp_stored_ff <= res_stored_ff;
         rsp_slot_ff   <= res_slot_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_hit    = rsp_hit_ff;
   assign rsp_stored = rsp_stored_ff;
   assign rsp_slot   = rsp_slot_ff;

   `SCD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready)
   `SCD_ASSERT_NEXT(a_timestamp_hold, clock, reset, !req_fire, $stable(timestamp_ff))
   `SCD_ASSERT_NEXT(a_lookup_no_store, clock, reset,
      (state_ff == ST_WRITE) && (cmd_ff == CMD_LOOKUP), !res_stored_ff)
   `SCD_ASSERT_SAME(a_no_write_on_read, clock, reset, mem_rd_en, !mem_wr_en)

endmodule

// ===== bench/sector_cache_directory_tb.sv =====
`timescale 1ns / 1ps

module sector_cache_directory_tb;
   import scd_pkg::*;

   localparam int SET_BITS = $clog2(DEF_SETS);
   localparam int ENTRIES = DEF_SETS * DEF_WAYS;
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   typedef struct packed {
      logic              hit;
      logic              stored;
      logic [SLOT_W-1:0] slot;
   } dir_result_type;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [SECTOR_W-1:0] sector;
      logic                start;
      logic                enable;
      logic                pinned;
      dir_result_type      want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd = CMD_LOOKUP;
   logic [SECTOR_W-1:0] req_sector = '0;
   logic                req_starts_request = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_hit;
   logic                rsp_stored;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                csr_write_enable = 1'b0;
   logic                csr_write_data = 1'b0;

   sector_cache_directory dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_sector         (req_sector),
      .req_starts_request (req_starts_request),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_stored         (rsp_stored),
      .rsp_slot           (rsp_slot),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // directory shadow
   logic             shadow_valid [ENTRIES];
   logic [TAG_W-1:0] shadow_tag [ENTRIES];
   logic [AGE_W-1:0] shadow_age [ENTRIES];
   logic [AGE_W-1:0] request_stamp;
   logic             fills_enabled;

   dir_result_type results_due [$];
   stim_row_type   directed_rows [$];
   int             mismatches = 0;
   int             req_calm_left = 0;
   int             rsp_calm_left = 0;

   logic [7:0]       set_pool [5] = '{8'd0, 8'd1, 8'd128, 8'd254, 8'd255};
   logic [TAG_W-1:0] tag_pool [6] = '{24'h000000, 24'h000001, 24'h000002,
                                      24'h5A5A5A, 24'h800000, 24'hFFFFFF};

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("sector_cache_directory_tb NOT OK");
      $finish;
   end

   function automatic int matching_way(int unsigned base, logic [TAG_W-1:0] tag);
      for (int w = 0; w < DEF_WAYS; w++) begin
         if (shadow_valid[base + w] && shadow_tag[base + w] == tag) begin
            return w;
         end
      end
      return -1;
   endfunction

   function automatic dir_result_type predict_directory(logic [CMD_W-1:0] cmd,
                                                        logic [SECTOR_W-1:0] sector,
                                                        logic start);
      dir_result_type   r;
      int unsigned      base;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] oldest;
      int               way;
      r = '0;
      base = sector[SET_BITS-1:0] * DEF_WAYS;
      tag = TAG_W'(sector >> SET_BITS);
      case (cmd)
         CMD_LOOKUP: begin
            if (start) begin
               request_stamp = request_stamp + 1;
            end
            way = matching_way(base, tag);
            if (way >= 0) begin
               shadow_age[base + way] = request_stamp;
               r.hit = 1'b1;
               r.slot = SLOT_W'(base + way);
            end
         end
         CMD_FILL: begin
            if (fills_enabled) begin
               way = matching_way(base, tag);
               if (way >= 0) begin
                  r.hit = 1'b1;
               end else begin
                  way = 0;
                  oldest = shadow_age[base];
                  for (int w = 1; w < DEF_WAYS; w++) begin
                     if (shadow_age[base + w] < oldest) begin
                        oldest = shadow_age[base + w];
                        way = w;
                     end
                  end
               end
               shadow_valid[base + way] = 1'b1;
               shadow_tag[base + way] = tag;
               shadow_age[base + way] = request_stamp;
               r.stored = 1'b1;
               r.slot = SLOT_W'(base + way);
            end
         end
         CMD_INVAL: begin
            for (int e = 0; e < ENTRIES; e++) begin
               shadow_valid[e] = 1'b0;
               shadow_age[e] = '0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int draw_pause(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(7) == 0) begin
         calm_left = $urandom_range(40, 10);
         return 0;
      end
      return $urandom_range(11);
   endfunction

   // called at a clock edge; returns at the edge that accepts the item
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [SECTOR_W-1:0] sector,
                            logic start, logic pinned, dir_result_type want);
      int             gap;
      dir_result_type due;
      gap = draw_pause(req_calm_left);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_sector <= sector;
      req_starts_request <= start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due = predict_directory(cmd, sector, start);
      results_due.push_back(pinned ? want : due);
   endtask

   task automatic write_enable(logic value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      fills_enabled = value;
   endtask

   task automatic add_row(logic [CMD_W-1:0] cmd, logic [SECTOR_W-1:0] sector,
                          logic start, logic enable, logic pinned,
                          logic hit, logic stored, logic [SLOT_W-1:0] slot);
      stim_row_type row;
      row.cmd = cmd;
      row.sector = sector;
      row.start = start;
      row.enable = enable;
      row.pinned = pinned;
      row.want = '{hit: hit, stored: stored, slot: slot};
      directed_rows.push_back(row);
   endtask

   task automatic random_item(output logic [CMD_W-1:0] cmd,
                              output logic [SECTOR_W-1:0] sector,
                              output logic start);
      int pick;
      pick = $urandom_range(99);
      start = 1'($urandom_range(1));
      sector = {tag_pool[$urandom_range(5)], set_pool[$urandom_range(4)]};
      cmd = ($urandom_range(99) < 55) ? CMD_LOOKUP : CMD_FILL;
      if (pick < 2) begin
         cmd = CMD_INVAL;
      end else if (pick < 3) begin
         cmd = CMD_RESERVED;
      end else if (pick < 10) begin
         sector = $urandom;
      end
      if (sector == '1) begin
         sector[0] = 1'b0;
      end
   endtask

   // results side: ready with random stalls, checked against the oldest prediction
   initial begin
      int stall;
      forever begin
         stall = draw_pause(rsp_calm_left);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      dir_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            $display("%0t: unexpected item hit=%0d stored=%0d slot=%0d", $time,
                     rsp_hit, rsp_stored, rsp_slot);
            mismatches++;
         end else begin
            want = results_due.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit expected %0d actual %0d", $time, want.hit, rsp_hit);
               mismatches++;
            end
            if (rsp_stored !== want.stored) begin
               $display("%0t: stored expected %0d actual %0d", $time, want.stored,
                        rsp_stored);
               mismatches++;
            end
            if (rsp_slot !== want.slot) begin
               $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_slot);
               mismatches++;
            end
         end
      end
   end

   initial begin
      logic [CMD_W-1:0]    cmd;
      logic [SECTOR_W-1:0] sector;
      logic                start;
      logic                phase_enable [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      int                  phase_items [5] = '{250, 100, 250, 100, 200};

      for (int e = 0; e < ENTRIES; e++) begin
         shadow_valid[e] = 1'b0;
         shadow_tag[e] = '0;
         shadow_age[e] = '0;
      end
      request_stamp = '0;
      fills_enabled = 1'b1;

      add_row(CMD_LOOKUP, 32'h0000_0000, 1, 1, 1, 0, 0, 0);
      add_row(CMD_LOOKUP, 32'hFFFF_FFFE, 0, 1, 1, 0, 0, 0);
      add_row(CMD_FILL,   32'h0000_0000, 0, 1, 1, 0, 1, 0);
      add_row(CMD_LOOKUP, 32'h0000_0000, 1, 1, 1, 1, 0, 0);
      add_row(CMD_FILL,   32'hFFFF_FFFE, 1, 1, 1, 0, 1, 1016);
      add_row(CMD_FILL,   32'hFFFF_FFFE, 0, 1, 1, 1, 1, 1016);
      add_row(CMD_LOOKUP, 32'hFFFF_FFFE, 1, 1, 1, 1, 0, 1016);
      add_row(CMD_FILL,   32'h0000_0100, 0, 1, 0, 0, 0, 0);
      add_row(CMD_FILL,   32'h0000_0200, 1, 1, 0, 0, 0, 0);
      add_row(CMD_FILL,   32'h0000_0300, 0, 1, 0, 0, 0, 0);
      // set full: oldest way goes
      add_row(CMD_FILL,   32'h0000_0400, 0, 1, 0, 0, 0, 0);
      add_row(CMD_LOOKUP, 32'h0000_0000, 0, 1, 1, 0, 0, 0);
      add_row(CMD_LOOKUP, 32'h0000_0100, 1, 1, 0, 0, 0, 0);
      add_row(CMD_FILL,   32'h0000_0500, 0, 1, 0, 0, 0, 0);
      add_row(CMD_RESERVED, 32'h0000_0100, 1, 1, 1, 0, 0, 0);
      add_row(CMD_LOOKUP, 32'h0000_0100, 0, 1, 0, 0, 0, 0);
      // cache off
      add_row(CMD_FILL,   32'h0000_0600, 0, 0, 1, 0, 0, 0);
      add_row(CMD_LOOKUP, 32'h0000_0600, 1, 0, 1, 0, 0, 0);
      add_row(CMD_FILL,   32'h0000_00FF, 1, 0, 1, 0, 0, 0);
      add_row(CMD_INVAL,  32'h0000_0100, 1, 1, 1, 0, 0, 0);
      add_row(CMD_LOOKUP, 32'h0000_0100, 1, 1, 1, 0, 0, 0);
      add_row(CMD_FILL,   32'h0000_0100, 0, 1, 1, 0, 1, 0);
      add_row(CMD_FILL,   32'h7FFF_FFFF, 0, 1, 1, 0, 1, 1020);
      add_row(CMD_FILL,   32'h5555_55AA, 1, 1, 0, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_enable(1'b1);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].enable != fills_enabled) begin
            write_enable(directed_rows[i].enable);
         end
         send_item(directed_rows[i].cmd, directed_rows[i].sector, directed_rows[i].start,
                   directed_rows[i].pinned, directed_rows[i].want);
      end

      for (int p = 0; p < 5; p++) begin
         if (phase_enable[p] != fills_enabled) begin
            write_enable(phase_enable[p]);
         end
         for (int n = 0; n < phase_items[p]; n++) begin
            random_item(cmd, sector, start);
            send_item(cmd, sector, start, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("sector_cache_directory_tb OK");
      end else begin
         $display("sector_cache_directory_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/scd_pkg.sv
rtl/scd_ram.sv
rtl/scd_way_unit.sv
rtl/sector_cache_directory.sv
bench/sector_cache_directory_tb.sv
